// File: design/spq_pkg.sv
// Shared types, constants and codes for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int REM_W   = 6;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [IDX_W-1:0]          index_t;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_DELETE,
        ST_READ
    } state_t;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic   ins_en;
        logic   del_en;
        value_t key;
    } chain_ctl_t;

endpackage

// File: design/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::chain_ctl_t ctl,
    input  logic               occupied,
    input  logic               prev_gt,
    input  spq_pkg::value_t    prev_val,
    input  spq_pkg::value_t    next_val,
    output logic               gt,
    output logic               match,
    output spq_pkg::value_t    val
);

    spq_pkg::value_t val_reg;
    spq_pkg::value_t val_next;

    assign gt    = occupied && (val_reg > ctl.key);
    assign match = occupied && (val_reg == ctl.key);
    assign val   = val_reg;

    // On insert, cells past the insertion point take their left neighbor and the
    // first cell not greater than the key takes the key. On delete, every cell at
    // or after the run of matches takes its right neighbor, removing one match.
    always_comb
    begin
        val_next = val_reg;
        if (ctl.ins_en)
        begin
            if (!prev_gt)
            begin
                val_next = prev_val;
            end
            else if (!gt)
            begin
                val_next = ctl.key;
            end
        end
        else if (ctl.del_en && !gt)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// File: design/spq_chain.sv
// Row of storage cells with the match summary and the read-out selector.
module spq_chain (
    input  logic                clk,
    input  spq_pkg::chain_ctl_t ctl,
    input  spq_pkg::count_t     count,
    input  spq_pkg::index_t     rd_idx,
    output logic                any_match,
    output spq_pkg::value_t     rd_value
);

    logic [spq_pkg::DEPTH-1:0] gt;
    logic [spq_pkg::DEPTH-1:0] match;
    spq_pkg::value_t           vals [spq_pkg::DEPTH];

    genvar i;
    generate
        for (i = 0; i < spq_pkg::DEPTH; i++)
        begin : g_cell
            localparam spq_pkg::count_t POS = spq_pkg::CNT_W'(i);
            logic            prev_gt;
            spq_pkg::value_t prev_val;
            spq_pkg::value_t next_val;

            if (i == 0)
            begin : g_head
                assign prev_gt  = 1'b1;
                assign prev_val = '0;
            end
            else
            begin : g_body
                assign prev_gt  = gt[i-1];
                assign prev_val = vals[i-1];
            end

            if (i == spq_pkg::DEPTH - 1)
            begin : g_tail
                assign next_val = '0;
            end
            else
            begin : g_inner
                assign next_val = vals[i+1];
            end

            spq_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .occupied (count > POS),
                .prev_gt  (prev_gt),
                .prev_val (prev_val),
                .next_val (next_val),
                .gt       (gt[i]),
                .match    (match[i]),
                .val      (vals[i])
            );
        end
    endgenerate

    assign any_match = |match;
    assign rd_value  = vals[rd_idx];

endmodule

// File: design/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller, entry count and result register.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, mode, value                | into block
//  out     | out_valid, out_ready, status, entry_value,     | out of block
//          | entry_position, removed_count, last            |
//
// One request is taken at a time. An insert gives one result, a delete
// removes the matching entries (the chain drops one match per cycle) and
// then gives one result, and a read-out gives one result per stored entry
// (one when the store is empty) through the single read selector. Reset
// clears the entry count and the controller; the stored values need no
// reset. A stalled result holds in the output register and the controller
// waits for it before producing the next one.
module sorted_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic signed [31:0] entry_value,
    output logic [4:0]  entry_position,
    output logic [5:0]  removed_count,
    output logic        last
);

    spq_pkg::state_t  state_reg, state_next;
    spq_pkg::count_t  count_reg, count_next;
    spq_pkg::count_t  removed_reg, removed_next;
    spq_pkg::index_t  ptr_reg, ptr_next;
    spq_pkg::value_t  key_reg, key_next;

    logic                   out_valid_reg, out_valid_next;
    spq_pkg::status_t       status_reg, status_next;
    spq_pkg::value_t        entry_value_reg, entry_value_next;
    logic [spq_pkg::POS_W-1:0] entry_position_reg, entry_position_next;
    logic [spq_pkg::REM_W-1:0] removed_count_reg, removed_count_next;
    logic                   last_reg, last_next;

    spq_pkg::chain_ctl_t ctl;
    logic                any_match;
    spq_pkg::value_t     rd_value;

    logic              accept;
    logic              emit_ok;
    logic              emit;
    spq_pkg::status_t  emit_status;
    spq_pkg::value_t   emit_value;
    logic              emit_last;
    logic              rd_last;
    logic              is_full;
    logic              is_empty;

    assign accept   = in_valid && in_ready;
    assign emit_ok  = !out_valid_reg || out_ready;
    assign is_full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);
    assign rd_last  = ((spq_pkg::CNT_W'(ptr_reg) + spq_pkg::CNT_W'(1)) == count_reg);

    spq_chain u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_reg),
        .rd_idx    (ptr_reg),
        .any_match (any_match),
        .rd_value  (rd_value)
    );

    // Controller outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        emit        = 1'b0;
        emit_status = spq_pkg::STATUS_OK;
        emit_value  = '0;
        emit_last   = 1'b1;
        ctl.ins_en  = 1'b0;
        ctl.del_en  = 1'b0;
        ctl.key     = key_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            spq_pkg::ST_INSERT:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    if (is_full)
                    begin
                        emit_status = spq_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        ctl.ins_en = 1'b1;
                    end
                end
            end
            spq_pkg::ST_DELETE:
            begin
                // A store emptied by this delete still reports ok with its count.
                if (is_empty && (removed_reg == '0))
                begin
                    emit        = emit_ok;
                    emit_status = spq_pkg::STATUS_EMPTY;
                end
                else if (any_match)
                begin
                    ctl.del_en = 1'b1;
                end
                else
                begin
                    emit = emit_ok;
                end
            end
            spq_pkg::ST_READ:
            begin
                emit = emit_ok;
                if (is_empty)
                begin
                    emit_status = spq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    emit_value = rd_value;
                    emit_last  = rd_last;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        spq_pkg::MODE_INSERT: state_next = spq_pkg::ST_INSERT;
                        spq_pkg::MODE_DELETE: state_next = spq_pkg::ST_DELETE;
                        spq_pkg::MODE_READ:   state_next = spq_pkg::ST_READ;
                        default:              state_next = spq_pkg::ST_IDLE;
                    endcase
                end
            end
            spq_pkg::ST_INSERT,
            spq_pkg::ST_DELETE,
            spq_pkg::ST_READ:
            begin
                if (emit && emit_last)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers and the result register.
    always_comb
    begin
        count_next   = count_reg;
        removed_next = removed_reg;
        ptr_next     = ptr_reg;
        key_next     = key_reg;
        if (accept)
        begin
            key_next     = value;
            removed_next = '0;
            ptr_next     = '0;
        end
        if (ctl.ins_en)
        begin
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end
        if (ctl.del_en)
        begin
            count_next   = count_reg - spq_pkg::CNT_W'(1);
            removed_next = removed_reg + spq_pkg::CNT_W'(1);
        end
        if (emit && (state_reg == spq_pkg::ST_READ))
        begin
            ptr_next = ptr_reg + spq_pkg::IDX_W'(1);
        end

        out_valid_next      = out_valid_reg && !out_ready;
        status_next         = status_reg;
        entry_value_next    = entry_value_reg;
        entry_position_next = entry_position_reg;
        removed_count_next  = removed_count_reg;
        last_next           = last_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            status_next         = emit_status;
            entry_value_next    = emit_value;
            entry_position_next = '0;
            removed_count_next  = '0;
            last_next           = emit_last;
            if ((state_reg == spq_pkg::ST_READ) && !is_empty)
            begin
                entry_position_next = spq_pkg::POS_W'(ptr_reg);
            end
            if (state_reg == spq_pkg::ST_DELETE)
            begin
                removed_count_next = spq_pkg::REM_W'(removed_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg        <= removed_next;
        ptr_reg            <= ptr_next;
        key_reg            <= key_next;
        status_reg         <= status_next;
        entry_value_reg    <= entry_value_next;
        entry_position_reg <= entry_position_next;
        removed_count_reg  <= removed_count_next;
        last_reg           <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign entry_value    = entry_value_reg;
    assign entry_position = entry_position_reg;
    assign removed_count  = removed_count_reg;
    assign last           = last_reg;

endmodule

// File: design/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  mode,
    input logic signed [31:0] value,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic signed [31:0] entry_value,
    input logic [4:0]  entry_position,
    input logic [5:0]  removed_count,
    input logic        last
);

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_value) && $stable(entry_position)
            && $stable(removed_count) && $stable(last))
    else $error("stalled result changed");

    // An accepted request keeps the block busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode != 2'd3) |=> !in_ready)
    else $error("request accepted while previous one in progress");

    // Only a read-out produces more than one result, and all of them are ok.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == spq_pkg::STATUS_OK)
    else $error("non-final result with error status");

    // A delete count comes alone, with no read-out fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (removed_count != 6'd0) |-> status == spq_pkg::STATUS_OK
            && entry_value == 32'sd0 && entry_position == 5'd0 && last)
    else $error("delete result carries read-out fields");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);
